// ----- hw/rtl/cpv_pkg.sv -----
// Shared types, opcodes and constants of the cascaded position/velocity PID unit.
// Used by the controller, the datapath, the divider and the top level.
package cpv_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int GAIN_SHIFT   = 24;
  localparam int SPEED_LEVELS = 10;
  localparam int ONE_Q        = 1 << FRAC_BITS;

  localparam int ALPHA_Q      = (2 * ONE_Q + 5) / 10;
  localparam int OVERSPEED_Q  = 150 * ONE_Q;
  localparam int WINDOW_PAD   = 400;
  localparam int RAMP_STEP_Q  = 2 * ONE_Q;
  localparam int VI_LIMIT_Q   = (45 * ONE_Q + 50) / 100;
  localparam int NEUTRAL_V    = (5 * ONE_Q) / 2;
  localparam int MAX_V        = 5 * ONE_Q;
  localparam int LONG_GAP_MS  = 20;

  localparam int DIV_W = 48;
  localparam logic [DIV_W-1:0] POS_LIM_NUM = DIV_W'(5) << GAIN_SHIFT;
  localparam logic [DIV_W-1:0] VEL_LIM_NUM = DIV_W'(VI_LIMIT_Q) << GAIN_SHIFT;
  localparam logic [61:0] PROD_LIMIT = 62'd1 << 61;

  localparam logic [1:0] TRIP_OK        = 2'd0;
  localparam logic [1:0] TRIP_OVERSPEED = 2'd1;
  localparam logic [1:0] TRIP_LOW       = 2'd2;
  localparam logic [1:0] TRIP_HIGH      = 2'd3;

  typedef enum logic [2:0] {
    REG_POS_KP, REG_POS_KI, REG_VEL_KP, REG_VEL_KI,
    REG_VEL_KD, REG_SPEED_LEVEL, REG_TRAVEL_START, REG_TRAVEL_END
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_VDIV_START, OP_RAW, OP_FSET, OP_FUSE, OP_CHECK,
    OP_PLIM_START, OP_PINT, OP_PACC, OP_PDES, OP_RAMP, OP_VERR,
    OP_VLIM_START, OP_VINT, OP_VISET, OP_VIACC, OP_DACC, OP_VOLT, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic neutral;
    logic dt_long;
    logic tripped;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] encoder_position;
    logic [30:0]        target_position;
    logic [15:0]        elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [18:0]        drive_voltage;
    logic [1:0]         trip_status;
    logic signed [31:0] filtered_velocity;
  } out_t;

  // Speed limit in counts per ms for a level index (level minus one).
  function automatic logic [6:0] level_speed(input logic [3:0] idx);
    logic [6:0] v;
    case (idx)
      4'd0: v = 7'd1;
      4'd1: v = 7'd2;
      4'd2: v = 7'd4;
      4'd3: v = 7'd8;
      4'd4: v = 7'd14;
      4'd5: v = 7'd22;
      4'd6: v = 7'd32;
      4'd7: v = 7'd44;
      4'd8: v = 7'd55;
      default: v = 7'd65;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/cpv_divider.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on cpv_pkg for the numerator width.
module cpv_divider import cpv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   dreg;
  logic [DIV_W-1:0] q;
  logic [32:0]   r2;
  logic [32:0]   diff;
  logic          ge;

  assign r2   = {rem, q[DIV_W-1]};
  assign diff = r2 - {1'b0, dreg};
  assign ge   = r2 >= {1'b0, dreg};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : r2[31:0];
      q   <= {q[DIV_W-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/cpv_datapath.sv -----
// Datapath: configuration registers, loop state, shared multiplier and divider.
// Depends on cpv_pkg and cpv_divider; driven one operation per cycle by cpv_ctrl.
module cpv_datapath import cpv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_op_t      op,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output dp_stat_t    stat,
  output out_t        out_data
);

  localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
  localparam logic signed [48:0] S32_MIN = -49'sd2147483648;
  localparam logic signed [31:0] OVR_POS = 32'(OVERSPEED_Q);
  localparam logic signed [31:0] OVR_NEG = -32'(OVERSPEED_Q);
  localparam logic signed [24:0] STEP25  = 25'(RAMP_STEP_Q);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'h7fffffff;
    else if (x < S32_MIN) r = 32'h80000000;
    else r = 32'(x);
    return r;
  endfunction

  function automatic logic [39:0] mag40(input logic signed [40:0] x);
    logic [40:0] m;
    m = x[40] ? 41'(-x) : 41'(x);
    return m[39:0];
  endfunction

  // Configuration
  logic [31:0] kp_pos, ki_pos, kp_vel, ki_vel, kd_vel;
  logic [3:0]  speed_lvl;
  logic [30:0] trav_a, trav_b;

  // Captured item
  logic               mode_q;
  logic signed [31:0] enc_q;
  logic [30:0]        tgt_q;
  logic [15:0]        dt_q;

  // Loop state
  logic signed [31:0] last_pos;
  logic               primed;
  logic signed [31:0] svel;
  logic signed [23:0] ramp;
  logic signed [27:0] pint;
  logic signed [39:0] vint;
  logic signed [31:0] prev_verr;
  logic [18:0]        held;

  // Working registers
  logic signed [31:0] delta_q, raw_q, verr_q;
  logic signed [32:0] err_q, vd_q;
  logic signed [23:0] desired;
  logic signed [63:0] acc;
  logic [1:0]         trip;
  out_t               out_q;

  // Shared multiplier with a saturating product register
  logic [31:0] mul_g;
  logic [39:0] mul_mag;
  logic        mul_neg;
  logic [71:0] mul_full;
  logic [61:0] prod_mag;
  logic        prod_neg;
  logic signed [62:0] prod_s;

  assign mul_full = 72'(mul_g) * 72'(mul_mag);
  assign prod_s   = prod_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

  always_ff @(posedge clk) begin
    prod_mag <= (mul_full > 72'(PROD_LIMIT)) ? PROD_LIMIT : mul_full[61:0];
    prod_neg <= mul_neg;
  end

  // Divider
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [31:0]      div_den;
  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [31:0]      abs_delta;

  assign abs_delta = delta_q[31] ? 32'(-delta_q) : 32'(delta_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = POS_LIM_NUM;
    div_den   = ki_pos;
    case (op)
      OP_VDIV_START: begin
        div_start = 1'b1;
        div_num   = DIV_W'(abs_delta) << FRAC_BITS;
        div_den   = 32'(dt_q);
      end
      OP_PLIM_START: begin
        div_start = 1'b1;
      end
      OP_VLIM_START: begin
        div_start = 1'b1;
        div_num   = VEL_LIM_NUM;
        div_den   = ki_vel;
      end
      default: ;
    endcase
  end

  cpv_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // Combinational helpers for the operations
  logic [15:0]        in_dt;
  logic signed [31:0] in_delta;
  logic signed [48:0] quot_s, raw_s;
  logic signed [32:0] fdiff;
  logic signed [48:0] fsum;
  logic [30:0]        lo, hi;
  logic signed [33:0] enc34, lo34, hi34;
  logic               win_on;
  logic [1:0]         trip_c;
  logic signed [49:0] plim, psum, vlim, vsum;
  logic signed [63:0] qsum, dsh;
  logic [3:0]         lvl;
  logic signed [23:0] maxv;
  logic signed [24:0] rdiff;
  logic signed [31:0] verr_c;
  logic signed [63:0] vsh;
  logic signed [41:0] volt;

  always_comb begin
    in_dt    = (in_data.elapsed_ms == 16'd0) ? 16'd1 : in_data.elapsed_ms;
    in_delta = primed ? in_data.encoder_position - last_pos : 32'sd0;
    quot_s   = $signed({1'b0, quot});
    raw_s    = delta_q[31] ? -quot_s : quot_s;
    fdiff    = 33'(raw_q) - 33'(svel);
    fsum     = 49'(svel) + 49'(prod_s >>> FRAC_BITS);

    lo     = (trav_a < trav_b) ? trav_a : trav_b;
    hi     = (trav_a > trav_b) ? trav_a : trav_b;
    enc34  = 34'(enc_q);
    lo34   = $signed({3'b0, lo}) - 34'sd400;
    hi34   = $signed({3'b0, hi}) + 34'(WINDOW_PAD);
    win_on = (trav_a != 31'd0) || (trav_b != 31'd0);
    if (svel > OVR_POS || svel < OVR_NEG) trip_c = TRIP_OVERSPEED;
    else if (win_on && enc34 < lo34) trip_c = TRIP_LOW;
    else if (win_on && enc34 > hi34) trip_c = TRIP_HIGH;
    else trip_c = TRIP_OK;

    plim = $signed({2'b0, quot});
    psum = 50'(pint) + 50'(err_q);
    vlim = plim;
    vsum = 50'(vint) + 50'(verr_q);

    qsum = acc + 64'(prod_s);
    dsh  = (-qsum) >>> (GAIN_SHIFT - FRAC_BITS);
    if (speed_lvl == 4'd0) lvl = 4'd1;
    else if (speed_lvl > 4'(SPEED_LEVELS)) lvl = 4'(SPEED_LEVELS);
    else lvl = speed_lvl;
    maxv = 24'(level_speed(lvl - 4'd1)) << FRAC_BITS;

    rdiff  = 25'(desired) - 25'(ramp);
    verr_c = sat32(49'(svel) - 49'(ramp));
    vsh    = acc >>> GAIN_SHIFT;
    volt   = 42'(vsh) + 42'(NEUTRAL_V);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_pos    <= 32'd2013266;
      ki_pos    <= 32'd0;
      kp_vel    <= 32'd419430;
      ki_vel    <= 32'd4194;
      kd_vel    <= 32'd0;
      speed_lvl <= 4'd7;
      trav_a    <= '0;
      trav_b    <= '0;
      last_pos  <= '0;
      primed    <= 1'b0;
      svel      <= '0;
      ramp      <= '0;
      pint      <= '0;
      vint      <= '0;
      prev_verr <= '0;
      held      <= 19'(NEUTRAL_V);
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_POS_KP:       kp_pos    <= cfg_wdata;
          REG_POS_KI:       ki_pos    <= cfg_wdata;
          REG_VEL_KP:       kp_vel    <= cfg_wdata;
          REG_VEL_KI:       ki_vel    <= cfg_wdata;
          REG_VEL_KD:       kd_vel    <= cfg_wdata;
          REG_SPEED_LEVEL:  speed_lvl <= cfg_wdata[3:0];
          REG_TRAVEL_START: trav_a    <= cfg_wdata[30:0];
          REG_TRAVEL_END:   trav_b    <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      case (op)
        OP_LOAD: begin
          mode_q   <= in_data.mode;
          enc_q    <= in_data.encoder_position;
          tgt_q    <= in_data.target_position;
          dt_q     <= in_dt;
          delta_q  <= in_delta;
          last_pos <= in_data.encoder_position;
          primed   <= 1'b1;
          trip     <= TRIP_OK;
          if (in_data.mode) begin
            svel      <= '0;
            ramp      <= '0;
            pint      <= '0;
            vint      <= '0;
            prev_verr <= '0;
            held      <= 19'(NEUTRAL_V);
          end else if (in_dt > 16'(LONG_GAP_MS)) begin
            svel <= '0;
          end
        end
        OP_RAW: raw_q <= sat32(raw_s);
        OP_FSET: begin
          mul_g   <= 32'(ALPHA_Q);
          mul_mag <= mag40(41'(fdiff));
          mul_neg <= fdiff[32];
        end
        OP_FUSE: svel <= sat32(fsum);
        OP_CHECK: begin
          trip  <= trip_c;
          err_q <= 33'(enc_q) - $signed({2'b0, tgt_q});
        end
        OP_PINT: begin
          if (ki_pos == 32'd0) pint <= '0;
          else if (psum > plim) pint <= 28'(plim);
          else if (psum < -plim) pint <= 28'(-plim);
          else pint <= 28'(psum);
          mul_g   <= kp_pos;
          mul_mag <= mag40(41'(err_q));
          mul_neg <= err_q[32];
        end
        OP_PACC: begin
          acc     <= 64'(prod_s);
          mul_g   <= ki_pos;
          mul_mag <= mag40(41'(pint));
          mul_neg <= pint[27];
        end
        OP_PDES: begin
          // A dead band of one count around the target gives no demand.
          if (err_q == 33'sd0 || err_q == 33'sd1 || err_q == -33'sd1) desired <= '0;
          else if (dsh > 64'(maxv)) desired <= maxv;
          else if (dsh < -64'(maxv)) desired <= -maxv;
          else desired <= 24'(dsh);
        end
        OP_RAMP: begin
          if (rdiff > STEP25) ramp <= ramp + 24'(RAMP_STEP_Q);
          else if (rdiff < -STEP25) ramp <= ramp - 24'(RAMP_STEP_Q);
          else ramp <= desired;
        end
        OP_VERR: begin
          verr_q  <= verr_c;
          mul_g   <= kp_vel;
          mul_mag <= mag40(41'(verr_c));
          mul_neg <= verr_c[31];
        end
        OP_VINT: begin
          acc <= 64'(prod_s);
          if (ki_vel == 32'd0) vint <= '0;
          else if (vsum > vlim) vint <= 40'(vlim);
          else if (vsum < -vlim) vint <= 40'(-vlim);
          else vint <= 40'(vsum);
          vd_q      <= 33'(verr_q) - 33'(prev_verr);
          prev_verr <= verr_q;
        end
        OP_VISET: begin
          mul_g   <= ki_vel;
          mul_mag <= mag40(41'(vint));
          mul_neg <= vint[39];
        end
        OP_VIACC: begin
          acc     <= qsum;
          mul_g   <= kd_vel;
          mul_mag <= mag40(41'(vd_q));
          mul_neg <= vd_q[32];
        end
        OP_DACC: acc <= qsum;
        OP_VOLT: begin
          if (volt < 42'sd0) held <= '0;
          else if (volt > 42'(MAX_V)) held <= 19'(MAX_V);
          else held <= 19'(volt);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_q.drive_voltage     <= held;
      out_q.trip_status       <= trip;
      out_q.filtered_velocity <= svel;
    end
  end

  assign out_data      = out_q;
  assign stat.neutral  = mode_q;
  assign stat.dt_long  = dt_q > 16'(LONG_GAP_MS);
  assign stat.tripped  = trip != TRIP_OK;
  assign stat.div_done = div_done;

endmodule

// ----- hw/rtl/cpv_ctrl.sv -----
// Sequencer of the PID unit: walks one control tick through the datapath.
// Depends on cpv_pkg for the operation codes and the status struct.
module cpv_ctrl import cpv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_VDIVW, S_FSET, S_FWAIT, S_FUSE, S_CHECK, S_TRIPBR,
    S_PLIMW, S_PWAIT1, S_PACC, S_PWAIT2, S_PDES, S_RAMP, S_VERR, S_VLIM,
    S_VLIMW, S_VISET, S_VIWAIT, S_VIACC, S_DWAIT, S_DACC, S_VOLT, S_OUT
  } state_t;

  state_t state, state_next;
  logic   out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        op = OP_LOAD;
        state_next = S_PREP;
      end
      S_PREP: begin
        if (stat.neutral) state_next = S_OUT;
        else if (stat.dt_long) state_next = S_CHECK;
        else begin
          op = OP_VDIV_START;
          state_next = S_VDIVW;
        end
      end
      S_VDIVW: if (stat.div_done) begin
        op = OP_RAW;
        state_next = S_FSET;
      end
      S_FSET: begin
        op = OP_FSET;
        state_next = S_FWAIT;
      end
      S_FWAIT: state_next = S_FUSE;
      S_FUSE: begin
        op = OP_FUSE;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        op = OP_CHECK;
        state_next = S_TRIPBR;
      end
      S_TRIPBR: begin
        if (stat.tripped) state_next = S_OUT;
        else begin
          op = OP_PLIM_START;
          state_next = S_PLIMW;
        end
      end
      S_PLIMW: if (stat.div_done) begin
        op = OP_PINT;
        state_next = S_PWAIT1;
      end
      S_PWAIT1: state_next = S_PACC;
      S_PACC: begin
        op = OP_PACC;
        state_next = S_PWAIT2;
      end
      S_PWAIT2: state_next = S_PDES;
      S_PDES: begin
        op = OP_PDES;
        state_next = S_RAMP;
      end
      S_RAMP: begin
        op = OP_RAMP;
        state_next = S_VERR;
      end
      S_VERR: begin
        op = OP_VERR;
        state_next = S_VLIM;
      end
      S_VLIM: begin
        op = OP_VLIM_START;
        state_next = S_VLIMW;
      end
      S_VLIMW: if (stat.div_done) begin
        op = OP_VINT;
        state_next = S_VISET;
      end
      S_VISET: begin
        op = OP_VISET;
        state_next = S_VIWAIT;
      end
      S_VIWAIT: state_next = S_VIACC;
      S_VIACC: begin
        op = OP_VIACC;
        state_next = S_DWAIT;
      end
      S_DWAIT: state_next = S_DACC;
      S_DACC: begin
        op = OP_DACC;
        state_next = S_VOLT;
      end
      S_VOLT: begin
        op = OP_VOLT;
        state_next = S_OUT;
      end
      S_OUT: if (out_load) begin
        op = OP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/cascaded_position_velocity_pid_unit.sv -----
// Top level of the cascaded position/velocity PID unit for one motor axis.
// Depends on cpv_pkg, cpv_ctrl and cpv_datapath.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one control tick:
//   mode, encoder position, target position and elapsed milliseconds. The
//   output channel (out_valid/out_ready/out_data) returns one result per
//   tick: drive voltage, trip status and filtered velocity.
//   Gains, speed level and travel window are written through cfg_we,
//   cfg_index and cfg_wdata while no tick is in flight.
//   A tick is worked on alone, and the next tick is taken only after the
//   result of the last one is loaded. A full control tick runs three
//   divisions in the shared divider (velocity and the two integral limits).
//   A tick after a gap above 20 ms skips the velocity division, a tripped
//   tick stops after the velocity update, and a neutral reset goes straight
//   to its result.
//   The result sits in an output register, so the next tick is taken while
//   a result still waits; a stalled receiver only holds back the following
//   result. Reset restores the default gains, the neutral 2.5 V held drive value and
//   clears the loop state; the first tick after it sees zero motion.
module cascaded_position_velocity_pid_unit import cpv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  dp_op_t   op;
  dp_stat_t stat;

  cpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  cpv_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
